[src/rau_pkg.sv]
// Shared types and codes for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

  // Operation codes carried in the input word's user field.
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_GT  = 4'd4,
    OP_LT  = 4'd5,
    OP_GE  = 4'd6,
    OP_LE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9
  } op_t;

  // Back-end sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_GCD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } bk_state_t;

  // Control part of one queued job.
  typedef struct packed {
    logic need_reduce;  // numerator and denominator still need gcd reduction
    logic cmp_true;     // comparison outcome
    logic div_zero;     // division by a zero fraction
  } job_ctl_t;

  localparam int unsigned FieldW = 16;
  localparam int unsigned ResNumW = 32;
  localparam int unsigned ResDenW = 31;

endpackage

[src/rau_front.sv]
// Front end: unpacks operands, forms cross products and classifies the operation.
`timescale 1ns / 1ps
module rau_front #(
  parameter int unsigned OPERAND_WIDTH = 16,
  parameter int unsigned EW = (OPERAND_WIDTH <= 16) ? OPERAND_WIDTH : 17,
  parameter int unsigned NW = 2 * EW + 1
) (
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [63:0]            in_tdata,
  input  logic [3:0]             in_tuser,
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic signed [NW-1:0]   q_num,
  output logic [NW-1:0]          q_den,
  output rau_pkg::job_ctl_t      q_ctl
);
  import rau_pkg::*;

  localparam int unsigned PW = 2 * EW;

  logic [FieldW-1:0]   raw [4];
  logic signed [EW-1:0] an, ad_raw, bn, bd_raw, ad, bd;
  logic signed [PW-1:0] left, right, pd, pm;
  logic signed [NW-1:0] left_x, right_x, pm_x;
  op_t                  op;

  assign raw[0] = in_tdata[15:0];
  assign raw[1] = in_tdata[31:16];
  assign raw[2] = in_tdata[47:32];
  assign raw[3] = in_tdata[63:48];
  assign op     = op_t'(in_tuser);

  // Operands no wider than the field are two's complement in its low bits;
  // wider ones have no sign bit and read as non-negative.
  generate
    if (OPERAND_WIDTH <= 16) begin : g_signed
      assign an     = $signed(raw[0][EW-1:0]);
      assign ad_raw = $signed(raw[1][EW-1:0]);
      assign bn     = $signed(raw[2][EW-1:0]);
      assign bd_raw = $signed(raw[3][EW-1:0]);
    end else begin : g_unsigned
      assign an     = $signed({1'b0, raw[0]});
      assign ad_raw = $signed({1'b0, raw[1]});
      assign bn     = $signed({1'b0, raw[2]});
      assign bd_raw = $signed({1'b0, raw[3]});
    end
  endgenerate

  // Denominators at or below zero count as one.
  assign ad = (ad_raw <= 0) ? EW'(1) : ad_raw;
  assign bd = (bd_raw <= 0) ? EW'(1) : bd_raw;

  // Cross products.
  assign left  = an * bd;
  assign right = ad * bn;
  assign pd    = ad * bd;
  assign pm    = an * bn;

  assign left_x  = NW'(left);
  assign right_x = NW'(right);
  assign pm_x    = NW'(pm);

  // Classify the operation into a reduction job or a direct result.
  always_comb begin
    q_num = '0;
    q_den = NW'(1);
    q_ctl = '{need_reduce: 1'b0, cmp_true: 1'b0, div_zero: 1'b0};
    unique case (op)
      OP_ADD: begin
        q_num = left_x + right_x;
        q_den = NW'($unsigned(pd));
        q_ctl.need_reduce = 1'b1;
      end
      OP_SUB: begin
        q_num = left_x - right_x;
        q_den = NW'($unsigned(pd));
        q_ctl.need_reduce = 1'b1;
      end
      OP_MUL: begin
        q_num = pm_x;
        q_den = NW'($unsigned(pd));
        q_ctl.need_reduce = 1'b1;
      end
      OP_DIV: begin
        if (bn == 0) begin
          q_ctl.div_zero = 1'b1;
        end else if (right < 0) begin
          q_num = -left_x;
          q_den = $unsigned(-right_x);
          q_ctl.need_reduce = 1'b1;
        end else begin
          q_num = left_x;
          q_den = $unsigned(right_x);
          q_ctl.need_reduce = 1'b1;
        end
      end
      OP_GT: q_ctl.cmp_true = (left > right);
      OP_LT: q_ctl.cmp_true = (left < right);
      OP_GE: q_ctl.cmp_true = (left >= right);
      OP_LE: q_ctl.cmp_true = (left <= right);
      OP_EQ: q_ctl.cmp_true = (left == right);
      OP_NE: q_ctl.cmp_true = (left != right);
      default: ;
    endcase
  end

  assign q_valid   = in_tvalid;
  assign in_tready = q_ready;

endmodule

[src/rau_queue.sv]
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
module rau_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);
  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)      count_r <= count_r + 2'd1;
      else if (do_pop && !do_push) count_r <= count_r - 2'd1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[src/rau_back.sv]
// Back end: binary gcd, exact division of both parts, and the output register.
`timescale 1ns / 1ps
module rau_back #(
  parameter int unsigned NW = 33
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_valid,
  output logic                            job_ready,
  input  logic signed [NW-1:0]            job_num,
  input  logic [NW-1:0]                   job_den,
  input  rau_pkg::job_ctl_t               job_ctl,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,
  output logic [1:0]                      out_tuser
);
  import rau_pkg::*;

  localparam int unsigned KW = $clog2(NW + 1);
  localparam int unsigned CW = $clog2(NW);

  bk_state_t              state_r;
  logic [NW-1:0]          x_r, y_r, g_r;
  logic [KW-1:0]          k_r;
  logic [CW-1:0]          cnt_r;
  logic                   neg_r;
  logic [NW-1:0]          qn_r, qd_r;
  logic [NW:0]            rn_r, rd_r;
  logic [NW:0]            rn_sh, rd_sh, g_x;
  logic signed [NW:0]     snum;
  logic [ResNumW-1:0]     res_num_r;
  logic [ResDenW-1:0]     res_den_r;
  logic                   cmp_r, dz_r;
  logic                   out_valid_r;
  logic [63:0]            out_data_nxt;
  logic [1:0]             out_user_nxt;
  logic                   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign job_ready = (state_r == ST_IDLE);
  assign rn_sh     = {rn_r[NW-1:0], qn_r[NW-1]};
  assign rd_sh     = {rd_r[NW-1:0], qd_r[NW-1]};
  assign g_x       = {1'b0, g_r};
  assign snum      = neg_r ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});

  // Sequencer: gcd by halving and subtraction, then restoring division.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            neg_r <= job_num[NW-1];
            x_r   <= job_num[NW-1] ? NW'(-job_num) : job_num;
            y_r   <= job_den;
            qn_r  <= job_num[NW-1] ? NW'(-job_num) : job_num;
            qd_r  <= job_den;
            k_r   <= '0;
            cmp_r <= job_ctl.cmp_true;
            dz_r  <= job_ctl.div_zero;
            if (job_ctl.need_reduce) begin
              state_r <= ST_GCD;
            end else begin
              res_num_r <= '0;
              res_den_r <= ResDenW'(1);
              state_r   <= ST_DONE;
            end
          end
        end
        ST_GCD: begin
          if (x_r == '0) begin
            g_r     <= NW'(y_r << k_r);
            rn_r    <= '0;
            rd_r    <= '0;
            cnt_r   <= CW'(NW - 1);
            state_r <= ST_DIV;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + KW'(1);
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (x_r >= y_r) begin
            x_r <= x_r - y_r;
          end else begin
            y_r <= y_r - x_r;
          end
        end
        ST_DIV: begin
          // One quotient bit of each part per cycle.
          if (rn_sh >= g_x) begin
            rn_r <= rn_sh - g_x;
            qn_r <= {qn_r[NW-2:0], 1'b1};
          end else begin
            rn_r <= rn_sh;
            qn_r <= {qn_r[NW-2:0], 1'b0};
          end
          if (rd_sh >= g_x) begin
            rd_r <= rd_sh - g_x;
            qd_r <= {qd_r[NW-2:0], 1'b1};
          end else begin
            rd_r <= rd_sh;
            qd_r <= {qd_r[NW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result word handed to the output register.
  always_comb begin
    if (dz_r || cmp_r ||
        (res_den_r == ResDenW'(1) && res_num_r == '0 && !neg_r && qd_r == '0)) begin
      out_data_nxt = {1'b0, res_den_r, res_num_r};
    end else begin
      out_data_nxt = {1'b0, ResDenW'(qd_r), ResNumW'(snum)};
    end
    out_user_nxt = {dz_r, cmp_r};
  end

  // Output register: holds a finished word until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_tdata <= out_data_nxt;
      out_tuser <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[src/rational_arith_unit_top.sv]
// Top level of the rational arithmetic unit.
//
// Channel | Dir | Word contents (lowest bits first)
// in_     | in  | tdata: a_num, a_den, b_num, b_den; tuser: op
// out_    | out | tdata: res_num, res_den, zero pad; tuser: cmp_true, div_zero
//
// Comparisons, unused codes and division by zero skip the gcd and the divider and go
// from the queue through the idle and done states to the output register. Reducing
// items take one gcd step per cycle (one halving or subtraction each), then one
// quotient bit of each part per cycle over the product bits in the divider.
// A two-word queue lets the front accept while the back works; a stalled output holds
// the back end. Reset is synchronous and active low and empties queue and output.
`timescale 1ns / 1ps
module rational_arith_unit_top #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_num, a_den, b_num, b_den
  input  logic [3:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // res_num, res_den, zero pad
  output logic [1:0]  out_tuser   // cmp_true, div_zero
);
  import rau_pkg::*;

  localparam int unsigned EW = (OPERAND_WIDTH <= 16) ? OPERAND_WIDTH : 17;
  localparam int unsigned NW = 2 * EW + 1;
  localparam int unsigned QW = 2 * NW + $bits(job_ctl_t);

  logic                 f_valid, f_ready, b_valid, b_ready;
  logic signed [NW-1:0] f_num;
  logic [NW-1:0]        f_den;
  job_ctl_t             f_ctl, b_ctl;
  logic [QW-1:0]        b_data;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH), .EW(EW), .NW(NW)) u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_valid(f_valid), .q_ready(f_ready),
    .q_num(f_num), .q_den(f_den), .q_ctl(f_ctl)
  );

  rau_queue #(.DW(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready),
    .push_data({f_ctl, f_den, f_num}),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
  );

  assign b_ctl = job_ctl_t'(b_data[QW-1:2*NW]);

  rau_back #(.NW(NW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(b_valid), .job_ready(b_ready),
    .job_num($signed(b_data[NW-1:0])), .job_den(b_data[2*NW-1:NW]), .job_ctl(b_ctl),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

[src/rau_checker.sv]
// Port-level checks for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
module rau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  // A stalled result word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A comparison flag and a division error never come together.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("cmp_true and div_zero both set");

  // Flagged words carry the fraction 0/1.
  a_flag_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1]) |->
      out_tdata[31:0] == 32'd0 && out_tdata[62:32] == 31'd1)
    else $error("flagged word is not 0/1");

  // Denominator is never zero.
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[62:32] != 31'd0)
    else $error("zero denominator");

  // No word is offered at the first edge out of reset.
  a_rst: assert property (@(posedge clk) $past(!rst_n) && rst_n |-> !out_tvalid)
    else $error("word offered after reset");
endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

[tb/sv/rational_arith_unit_checker.sv]
// Checker for the rational arithmetic unit: predicts each result word and compares it.
`timescale 1ns / 1ps
module rational_arith_unit_checker
  import rau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        cmp_true;
    logic        div_zero;
  } fraction_result_t;

  fraction_result_t expected_q[$];
  int               fails = 0;

  assign pending_count = expected_q.size();
  assign fail_count    = fails;

  // Euclid on magnitudes.
  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Divides both parts by their common divisor; den is positive.
  function automatic void reduce_fraction(longint num, longint den, ref fraction_result_t r);
    longint unsigned g;
    longint q_num;
    longint q_den;
    g = gcd_of(num < 0 ? -num : num, den);
    if (g == 0) g = 1;
    q_num = num / longint'(g);
    q_den = den / longint'(g);
    r.num = q_num[31:0];
    r.den = q_den[30:0];
  endfunction

  // Works out the result word for one input word.
  function automatic fraction_result_t predict_fraction(logic [3:0] op, logic [63:0] d);
    fraction_result_t r;
    longint an, ad, bn, bd, left, right, qn, qd;
    an = longint'($signed(d[15:0]));
    ad = longint'($signed(d[31:16]));
    bn = longint'($signed(d[47:32]));
    bd = longint'($signed(d[63:48]));
    if (ad <= 0) ad = 1;
    if (bd <= 0) bd = 1;
    r = '{num: 32'd0, den: 31'd1, cmp_true: 1'b0, div_zero: 1'b0};
    left = an * bd;
    right = ad * bn;
    case (op)
      OP_ADD: reduce_fraction(left + right, ad * bd, r);
      OP_SUB: reduce_fraction(left - right, ad * bd, r);
      OP_MUL: reduce_fraction(an * bn, ad * bd, r);
      OP_DIV: begin
        if (bn == 0) begin
          r.div_zero = 1'b1;
        end else begin
          qn = left;
          qd = right;
          if (qd < 0) begin
            qn = -qn;
            qd = -qd;
          end
          reduce_fraction(qn, qd, r);
        end
      end
      OP_GT: r.cmp_true = left > right;
      OP_LT: r.cmp_true = left < right;
      OP_GE: r.cmp_true = left >= right;
      OP_LE: r.cmp_true = left <= right;
      OP_EQ: r.cmp_true = left == right;
      OP_NE: r.cmp_true = left != right;
      default: ;
    endcase
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // Watches both channels and compares at each accepted result word.
  always @(posedge clk) begin
    fraction_result_t want;
    if (rst_n && in_tvalid && in_tready)
      expected_q.push_back(predict_fraction(in_tuser, in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[31:0] !== want.num)
          report_mismatch("res_num", $signed(out_tdata[31:0]), $signed(want.num));
        if (out_tdata[62:32] !== want.den)
          report_mismatch("res_den", out_tdata[62:32], want.den);
        if (out_tdata[63] !== 1'b0)
          report_mismatch("pad bit", out_tdata[63], 0);
        if (out_tuser[0] !== want.cmp_true)
          report_mismatch("cmp_true", out_tuser[0], want.cmp_true);
        if (out_tuser[1] !== want.div_zero)
          report_mismatch("div_zero", out_tuser[1], want.div_zero);
      end
    end
  end

endmodule

[tb/sv/rational_arith_unit_top_tb.sv]
// Testbench top for the rational arithmetic unit: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module rational_arith_unit_top_tb;
  import rau_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          pending_count;

  int send_idle_pct = 13;
  int recv_idle_pct = 78;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  rational_arith_unit_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  rational_arith_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    out_tready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one word, with random idle cycles first, and waits for its acceptance.
  task automatic send_word(logic [3:0] op, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {bd, bn, ad, an};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Operand with a bias towards the edges and small values.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(6)) - 3);
      3, 4: return 16'(int'($urandom_range(40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_word(4'($urandom_range(15)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: every operation, field extremes, special cases.
    for (int op = 0; op < 10; op++)
      send_word(4'(op), 16'sd3, 16'sd4, -16'sd5, 16'sd6);
    send_word(OP_DIV, 16'sd7, 16'sd3, 16'sd0, 16'sd9);      // divide by zero fraction
    send_word(OP_DIV, 16'sd7, 16'sd3, -16'sd2, 16'sd9);     // negative divisor
    send_word(OP_ADD, 16'sd5, 16'sd0, 16'sd1, -16'sd4);     // non-positive denominators
    send_word(OP_SUB, 16'sd2, 16'sd3, 16'sd2, 16'sd3);      // zero result
    send_word(OP_MUL, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(OP_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_word(OP_DIV, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(OP_SUB, 16'h8000, 16'h0001, 16'h7FFF, 16'h0001);
    send_word(OP_EQ, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
    send_word(OP_NE, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
    send_word(4'd10, 16'sd1, 16'sd2, 16'sd3, 16'sd4);       // unused codes
    send_word(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // Random words in three idling phases.
    send_random(600);
    send_idle_pct = 78;
    recv_idle_pct = 13;
    send_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Long hold-off on the result side while words keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(40);
    join
    send_random(640);

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
src/rau_pkg.sv
src/rau_front.sv
src/rau_queue.sv
src/rau_back.sv
src/rational_arith_unit_top.sv
src/rau_checker.sv
tb/sv/rational_arith_unit_checker.sv
tb/sv/rational_arith_unit_top_tb.sv
